// ===== rtl/core/pidaw_pkg.sv =====
// Shared constants and types for the PID controller with anti-windup.
`default_nettype none

package pidaw_pkg;

  // Default data path geometry: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration register index width and register map.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_COEFF  = 3'd1,
    REG_DERIV_COEFF  = 3'd2,
    REG_FILTER_COEFF = 3'd3,
    REG_OUT_MIN      = 3'd4,
    REG_OUT_MAX      = 3'd5
  } cfg_reg_t;

  // Per-stage pipeline control: load enables the stage register, take marks
  // that a real word enters it (used to advance the controller state).
  typedef struct packed {
    logic load;
    logic take;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pidaw_mulq.sv =====
// Fixed-point multiply with round-half-up and saturation to the data width.
`default_nettype none

module pidaw_mulq #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [DW-1:0]      y
);

  localparam int PW = AW + BW + 1;
  localparam int SW = PW - FB;
  localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic signed [AW+BW-1:0] prod;
  logic        [PW-1:0]    rnd;
  logic        [SW-1:0]    shr;

  // Exact product, add one half LSB, then drop the fraction bits.
  always_comb begin
    prod = a * b;
    rnd  = {prod[AW+BW-1], prod} + HALF;
    shr  = rnd[PW-1:FB];
  end

  // Saturate when the shifted value does not fit the data width.
  if (SW > DW) begin : g_sat
    logic [SW-DW:0] upper;
    always_comb begin
      upper = shr[SW-1:DW-1];
      if ((&upper) || !(|upper)) begin
        y = shr[DW-1:0];
      end else if (shr[SW-1]) begin
        y = MINV;
      end else begin
        y = MAXV;
      end
    end
  end else begin : g_ext
    assign y = DW'($signed(shr));
  end

endmodule

`default_nettype wire

// ===== rtl/core/pidaw_error.sv =====
// Error stage: error, error pair sum and measurement step, with their history.
`default_nettype none

module pidaw_error #(
  parameter int DW = pidaw_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pidaw_pkg::stage_ctl_t ctl,
  input  wire logic signed [DW-1:0] target_q,
  input  wire logic signed [DW-1:0] meas_q,
  output logic signed [DW-1:0]      err,
  output logic signed [DW-1:0]      err_pair,
  output logic signed [DW-1:0]      meas_step
);

  import pidaw_pkg::*;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] z);
    logic [DW:0] s;
    s = {x[DW-1], x} + {z[DW-1], z};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] z);
    logic [DW:0] s;
    s = {x[DW-1], x} - {z[DW-1], z};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0] last_error;
  logic signed [DW-1:0] last_measured;
  logic signed [DW-1:0] err_next;

  assign err_next = sat_sub(target_q, meas_q);

  // Previous error and measurement advance once per real word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error    <= '0;
      last_measured <= '0;
    end else if (ctl.take) begin
      last_error    <= err_next;
      last_measured <= meas_q;
    end
  end

  // Stage register feeding the multipliers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      err       <= err_next;
      err_pair  <= sat_add(err_next, last_error);
      meas_step <= sat_sub(meas_q, last_measured);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pidaw_integ_deriv.sv =====
// State stage: clamped trapezoidal integrator and filtered derivative.
`default_nettype none

module pidaw_integ_deriv #(
  parameter int DW = pidaw_pkg::DATA_WIDTH_DEF,
  parameter int FB = pidaw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pidaw_pkg::stage_ctl_t  ctl,
  input  wire logic signed [DW-1:0]   prop_in,
  input  wire logic signed [DW-1:0]   integ_step,
  input  wire logic signed [DW-1:0]   deriv_step,
  input  wire logic signed [FB+1:0]   filter_coeff,
  input  wire logic signed [DW-1:0]   out_min,
  input  wire logic signed [DW-1:0]   out_max,
  output logic signed [DW-1:0]        prop,
  output logic signed [DW-1:0]        integral_sum,
  output logic signed [DW-1:0]        deriv_term
);

  import pidaw_pkg::*;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] z);
    logic [DW:0] s;
    s = {x[DW-1], x} + {z[DW-1], z};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] z);
    logic [DW:0] s;
    s = {x[DW-1], x} - {z[DW-1], z};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0] lim_hi;
  logic signed [DW-1:0] lim_lo;
  logic signed [DW-1:0] integ_raw;
  logic signed [DW-1:0] integral_sum_next;
  logic signed [DW-1:0] deriv_decay;

  // Anti-windup bounds: the output limits less the proportional term,
  // pulled to zero when they sit on the wrong side of zero.
  always_comb begin
    lim_hi = (out_max > prop_in) ? sat_sub(out_max, prop_in) : '0;
    lim_lo = (out_min < prop_in) ? sat_sub(out_min, prop_in) : '0;
    integ_raw = sat_add(integral_sum, integ_step);
    priority if (integ_raw > lim_hi) begin
      integral_sum_next = lim_hi;
    end else if (integ_raw < lim_lo) begin
      integral_sum_next = lim_lo;
    end else begin
      integral_sum_next = integ_raw;
    end
  end

  // Derivative filter pole: filter_coeff times the previous derivative.
  pidaw_mulq #(
    .AW(FB + 2),
    .BW(DW),
    .DW(DW),
    .FB(FB)
  ) u_filter_mul (
    .a(filter_coeff),
    .b(deriv_term),
    .y(deriv_decay)
  );

  // Controller state advances once per real word.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      deriv_term   <= '0;
    end else if (ctl.take) begin
      integral_sum <= integral_sum_next;
      deriv_term   <= sat_sub(deriv_decay, deriv_step);
    end
  end

  // Proportional term travels alongside the state.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prop <= prop_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pidaw_output.sv =====
// Output stage: sum of the three terms, clamp to the limits, output register.
`default_nettype none

module pidaw_output #(
  parameter int DW = pidaw_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire pidaw_pkg::stage_ctl_t ctl,
  input  wire logic signed [DW-1:0]  prop,
  input  wire logic signed [DW-1:0]  integral_sum,
  input  wire logic signed [DW-1:0]  deriv_term,
  input  wire logic signed [DW-1:0]  out_min,
  input  wire logic signed [DW-1:0]  out_max,
  output logic signed [DW-1:0]       drive_value,
  output logic                       saturated
);

  import pidaw_pkg::*;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] x,
                                                   input logic signed [DW-1:0] z);
    logic [DW:0] s;
    s = {x[DW-1], x} + {z[DW-1], z};
    if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0] total;
  logic signed [DW-1:0] drive_next;
  logic                 saturated_next;

  // The upper limit is tested first, so a total above out_max gives out_max even when the limits are crossed.
  always_comb begin
    total = sat_add(sat_add(prop, integral_sum), deriv_term);
    priority if (total > out_max) begin
      drive_next     = out_max;
      saturated_next = 1'b1;
    end else if (total < out_min) begin
      drive_next     = out_min;
      saturated_next = 1'b1;
    end else begin
      drive_next     = total;
      saturated_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      drive_value <= drive_next;
      saturated   <= saturated_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pid_controller_antiwindup.sv =====
// Top level of the PID controller with trapezoidal integrator and anti-windup.
//
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   target_value, measured_value
//  output    out_valid / out_stall drive_value, saturated
//  config    cfg_write             cfg_index, cfg_data
//
// One word is accepted per cycle while out_stall is low; after acceptance a word passes
// through the input, error, multiply, state and output stage registers in order.
// The cycle time is set by the derivative filter multiply and subtract in the
// state stage feedback loop.
// Reset is synchronous: limits go to the full range, coefficients and state to zero.
// Each stage loads when it is empty or its successor moves, so bubbles close up;
// in_stall rises only when all five stages hold words and out_stall is high.
`default_nettype none

module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF,
  parameter int CFG_WIDTH  = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]            cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]    target_value,
  input  wire logic signed [DATA_WIDTH-1:0]    measured_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [DATA_WIDTH-1:0]         drive_value,
  output logic                                 saturated
);

  import pidaw_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int FW = FRAC_BITS + 2;
  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  // Configuration registers.
  logic signed [DW-1:0] prop_gain;
  logic signed [DW-1:0] integ_coeff;
  logic signed [DW-1:0] deriv_coeff;
  logic signed [FW-1:0] filter_coeff;
  logic signed [DW-1:0] out_min;
  logic signed [DW-1:0] out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_coeff  <= '0;
      deriv_coeff  <= '0;
      filter_coeff <= '0;
      out_min      <= MINV;
      out_max      <= MAXV;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    prop_gain    <= cfg_data[DW-1:0];
        REG_INTEG_COEFF:  integ_coeff  <= cfg_data[DW-1:0];
        REG_DERIV_COEFF:  deriv_coeff  <= cfg_data[DW-1:0];
        REG_FILTER_COEFF: filter_coeff <= cfg_data[FW-1:0];
        REG_OUT_MIN:      out_min      <= cfg_data[DW-1:0];
        REG_OUT_MAX:      out_max      <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and per-stage load enables.
  logic v_in, v_err, v_mul, v_state;
  logic go_in, go_err, go_mul, go_state, go_out;
  stage_ctl_t ctl_err, ctl_state, ctl_out;

  always_comb begin
    go_out   = !out_valid || !out_stall;
    go_state = !v_state || go_out;
    go_mul   = !v_mul || go_state;
    go_err   = !v_err || go_mul;
    go_in    = !v_in || go_err;
    in_stall = !go_in;
    ctl_err   = '{load: go_err,   take: go_err && v_in};
    ctl_state = '{load: go_state, take: go_state && v_mul};
    ctl_out   = '{load: go_out,   take: go_out && v_state};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      v_err     <= 1'b0;
      v_mul     <= 1'b0;
      v_state   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go_in)    v_in      <= in_valid;
      if (go_err)   v_err     <= v_in;
      if (go_mul)   v_mul     <= v_err;
      if (go_state) v_state   <= v_mul;
      if (go_out)   out_valid <= v_state;
    end
  end

  // Input register.
  logic signed [DW-1:0] target_q;
  logic signed [DW-1:0] meas_q;

  always_ff @(posedge clk) begin
    if (go_in) begin
      target_q <= target_value;
      meas_q   <= measured_value;
    end
  end

  // Error stage.
  logic signed [DW-1:0] err;
  logic signed [DW-1:0] err_pair;
  logic signed [DW-1:0] meas_step;

  pidaw_error #(
    .DW(DW)
  ) u_error (
    .clk(clk),
    .rst(rst),
    .ctl(ctl_err),
    .target_q(target_q),
    .meas_q(meas_q),
    .err(err),
    .err_pair(err_pair),
    .meas_step(meas_step)
  );

  // Multiply stage: proportional term, integrator step, derivative input.
  logic signed [DW-1:0] prop_mul, integ_mul, deriv_mul;
  logic signed [DW-1:0] prop_p, integ_step, deriv_step;

  pidaw_mulq #(.AW(DW), .BW(DW), .DW(DW), .FB(FRAC_BITS)) u_prop_mul (
    .a(prop_gain),
    .b(err),
    .y(prop_mul)
  );

  pidaw_mulq #(.AW(DW), .BW(DW), .DW(DW), .FB(FRAC_BITS)) u_integ_mul (
    .a(integ_coeff),
    .b(err_pair),
    .y(integ_mul)
  );

  pidaw_mulq #(.AW(DW), .BW(DW), .DW(DW), .FB(FRAC_BITS)) u_deriv_mul (
    .a(deriv_coeff),
    .b(meas_step),
    .y(deriv_mul)
  );

  always_ff @(posedge clk) begin
    if (go_mul) begin
      prop_p     <= prop_mul;
      integ_step <= integ_mul;
      deriv_step <= deriv_mul;
    end
  end

  // State stage.
  logic signed [DW-1:0] prop_s;
  logic signed [DW-1:0] integral_sum;
  logic signed [DW-1:0] deriv_term;

  pidaw_integ_deriv #(
    .DW(DW),
    .FB(FRAC_BITS)
  ) u_integ_deriv (
    .clk(clk),
    .rst(rst),
    .ctl(ctl_state),
    .prop_in(prop_p),
    .integ_step(integ_step),
    .deriv_step(deriv_step),
    .filter_coeff(filter_coeff),
    .out_min(out_min),
    .out_max(out_max),
    .prop(prop_s),
    .integral_sum(integral_sum),
    .deriv_term(deriv_term)
  );

  // Output stage.
  pidaw_output #(
    .DW(DW)
  ) u_output (
    .clk(clk),
    .ctl(ctl_out),
    .prop(prop_s),
    .integral_sum(integral_sum),
    .deriv_term(deriv_term),
    .out_min(out_min),
    .out_max(out_max),
    .drive_value(drive_value),
    .saturated(saturated)
  );

endmodule

`default_nettype wire
